@@ design/vsp_pkg.sv @@
// vsp_pkg: shared constants for the velocity sentence parser
// character codes, parameter defaults and the power-of-ten table
// no dependencies
`timescale 1ns / 1ps

package vsp_pkg;

    // parameter defaults
    localparam int DEF_FRAME_BYTES     = 128;
    localparam int DEF_FRACTION_DIGITS = 3;

    // magnitude clamp while digits accumulate and after scaling
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_I     = 8'h49;

    // 10 to the power k
    function automatic logic [31:0] pow10(input logic [2:0] k);
        logic [31:0] r;
        begin
            unique case (k)
                3'd0: r = 32'd1;
                3'd1: r = 32'd10;
                3'd2: r = 32'd100;
                3'd3: r = 32'd1000;
                3'd4: r = 32'd10000;
                3'd5: r = 32'd100000;
                3'd6: r = 32'd1000000;
                3'd7: r = 32'd10000000;
            endcase
            return r;
        end
    endfunction

endpackage

@@ design/velocity_sentence_parser_top.sv @@
// velocity_sentence_parser_top: streaming parser for bottom-track BI velocity sentences
// holds the byte register, parser state and result register
// depends on vsp_pkg and vsp_scale
`timescale 1ns / 1ps

// Takes one received character per item on rx_byte and, for every complete
// ":BI,<x>,<y>,<z>,<err>,<status>" line that ends in a line feed, gives one
// result: the four velocities in thousandths by default (FRACTION_DIGITS digits of
// fraction, extra digits truncated, saturated to signed 32 bits), the latest
// status character and a wrapping count of accepted frames. Carriage returns
// are dropped, a colon restarts a frame, and frames reaching FRAME_BYTES
// characters or with a bad header give nothing. The block takes one byte
// every cycle while it is not stalled: a byte is held in the input register,
// where its whole parse step (digit accumulate, or the power-of-ten scaling
// multiply at the end of a number) runs, then the state and the result register
// load. A line feed passes through the input register and then loads the result
// register. Input only stalls while a finished result waits in the result register
// with out_ready low and the next byte is already held.
module velocity_sentence_parser_top
    import vsp_pkg::*;
#(
    parameter int FRAME_BYTES     = DEF_FRAME_BYTES,
    parameter int FRACTION_DIGITS = DEF_FRACTION_DIGITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // byte channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [31:0] vel_err,
    output logic [7:0]         status_char,
    output logic [31:0]        frame_total
);

    // frame length counter just holds FRAME_BYTES-1
    localparam int LEN_W = $clog2(FRAME_BYTES);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(FRAME_BYTES - 1);
    localparam logic [2:0] FD = 3'(FRACTION_DIGITS);

    // parse phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_H1     = 4'd1;
    localparam logic [3:0] PH_H2     = 4'd2;
    localparam logic [3:0] PH_H3     = 4'd3;
    localparam logic [3:0] PH_FSTART = 4'd4;
    localparam logic [3:0] PH_FWS    = 4'd5;
    localparam logic [3:0] PH_FSIGN  = 4'd6;
    localparam logic [3:0] PH_FDOT   = 4'd7;
    localparam logic [3:0] PH_FINT   = 4'd8;
    localparam logic [3:0] PH_FFRAC  = 4'd9;
    localparam logic [3:0] PH_STAT   = 4'd10;
    localparam logic [3:0] PH_END    = 4'd11;

    // input register
    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       advance;

    // parser state
    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0]       phase_reg, phase_next;
    logic [2:0]       field_reg, field_next;
    logic [31:0]      acc_reg [4];
    logic [31:0]      acc_next [4];
    logic             neg_reg, neg_next;
    logic [2:0]       frac_reg, frac_next;
    logic [7:0]       status_reg, status_next;
    logic [31:0]      count_reg, count_next;
    logic             cand_ok_reg, cand_ok_next;
    logic [7:0]       cand_chr_reg, cand_chr_next;
    logic             pend_ok_reg, pend_ok_next;
    logic [7:0]       pend_chr_reg, pend_chr_next;

    // result register
    logic               out_valid_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg, vel_z_reg, vel_err_reg;
    logic [7:0]         status_out_reg;
    logic [31:0]        total_out_reg;

    // datapath helpers
    logic [31:0] acc_cur;
    logic [35:0] acc_ext;
    logic [35:0] acc_mul;
    logic [31:0] acc_dig;
    logic signed [31:0] fin_val;
    logic [7:0]  c;
    logic        c_ws;
    logic        c_sign;
    logic        c_digit;
    logic        emit;

    assign c = byte_reg;
    assign c_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    assign c_sign = (c == CH_PLUS) || (c == CH_MINUS);
    assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    // accumulate one decimal digit into the current field, clamped
    assign acc_cur = acc_reg[field_reg[1:0]];
    assign acc_ext = {4'd0, acc_cur};
    assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + {28'd0, c - CH_ZERO};
    assign acc_dig = (acc_mul > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : acc_mul[31:0];

    // end-of-number scaling for the current field
    vsp_scale #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_scale (
        .mag       (acc_cur),
        .frac_seen (frac_reg),
        .neg       (neg_reg),
        .value     (fin_val)
    );

    // handshake: the byte stage moves on when the result register can take it
    assign advance  = byte_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !byte_valid_reg || advance;

    always_comb
    begin
        logic do_te;
        logic again;
        logic in_frame;
        do_te = 1'b0;
        again = 1'b0;
        emit = 1'b0;
        len_next = len_reg;
        phase_next = phase_reg;
        field_next = field_reg;
        for (int i = 0; i < 4; i++)
        begin
            acc_next[i] = acc_reg[i];
        end
        neg_next = neg_reg;
        frac_next = frac_reg;
        status_next = status_reg;
        count_next = count_reg;
        cand_ok_next = cand_ok_reg;
        cand_chr_next = cand_chr_reg;
        pend_ok_next = pend_ok_reg;
        pend_chr_next = pend_chr_reg;
        in_frame = (phase_reg >= PH_FSTART) && (phase_reg <= PH_END);

        priority if (c == CH_COLON)
        begin
            // colon always opens a fresh frame
            len_next = LEN_W'(1);
            phase_next = PH_H1;
            field_next = 3'd0;
            for (int i = 0; i < 4; i++)
            begin
                acc_next[i] = 32'd0;
            end
            neg_next = 1'b0;
            frac_next = 3'd0;
            cand_ok_next = 1'b0;
            cand_chr_next = 8'd0;
            pend_ok_next = 1'b0;
            pend_chr_next = 8'd0;
        end
        else if (c == CH_LF)
        begin
            do_te = in_frame;
            emit = in_frame;
            len_next = '0;
        end
        else if (len_reg >= LEN_LIMIT)
        begin
            // overlong frame is dropped
            len_next = '0;
            phase_next = PH_IDLE;
        end
        else if (c == CH_CR)
        begin
            len_next = len_reg;
        end
        else
        begin
            len_next = len_reg + LEN_W'(1);
            if (c == CH_NUL)
            begin
                if (in_frame)
                begin
                    do_te = 1'b1;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                // first parse pass on the stored phase
                unique case (phase_reg)
                    PH_H1: phase_next = (c == CH_B) ? PH_H2 : PH_IDLE;
                    PH_H2: phase_next = (c == CH_I) ? PH_H3 : PH_IDLE;
                    PH_H3: phase_next = (c == CH_COMMA) ? PH_FSTART : PH_IDLE;
                    PH_FSTART, PH_FWS, PH_FSIGN:
                    begin
                        if (phase_reg == PH_FSTART && c == CH_COMMA)
                        begin
                            // empty field, value stays zero
                            field_next = field_reg + 3'd1;
                            neg_next = 1'b0;
                            frac_next = 3'd0;
                            cand_ok_next = 1'b0;
                            cand_chr_next = 8'd0;
                            phase_next = (field_next >= 3'd4) ? PH_STAT : PH_FSTART;
                        end
                        else if (phase_reg != PH_FSIGN && c_ws)
                        begin
                            if (!cand_ok_reg && c != CH_SPACE)
                            begin
                                cand_ok_next = 1'b1;
                                cand_chr_next = c;
                            end
                            phase_next = PH_FWS;
                        end
                        else if (phase_reg != PH_FSIGN && c_sign)
                        begin
                            if (!cand_ok_reg)
                            begin
                                cand_ok_next = 1'b1;
                                cand_chr_next = c;
                            end
                            neg_next = (c == CH_MINUS);
                            phase_next = PH_FSIGN;
                        end
                        else if (c == CH_DOT)
                        begin
                            if (!cand_ok_reg)
                            begin
                                cand_ok_next = 1'b1;
                                cand_chr_next = c;
                            end
                            phase_next = PH_FDOT;
                        end
                        else if (c_digit)
                        begin
                            acc_next[field_reg[1:0]] = acc_dig;
                            phase_next = PH_FINT;
                        end
                        else
                        begin
                            // not a number: take status, zero this field
                            if (cand_ok_reg)
                            begin
                                if (cand_chr_reg != CH_STAR)
                                begin
                                    pend_ok_next = 1'b1;
                                    pend_chr_next = cand_chr_reg;
                                end
                            end
                            else if (c != CH_STAR)
                            begin
                                pend_ok_next = 1'b1;
                                pend_chr_next = c;
                            end
                            if (field_reg < 3'd4)
                            begin
                                acc_next[field_reg[1:0]] = 32'd0;
                            end
                            phase_next = PH_END;
                        end
                    end
                    PH_FDOT:
                    begin
                        if (c_digit)
                        begin
                            phase_next = PH_FFRAC;
                            if (frac_reg < FD)
                            begin
                                acc_next[field_reg[1:0]] = acc_dig;
                                frac_next = frac_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            if (cand_ok_reg)
                            begin
                                if (cand_chr_reg != CH_STAR)
                                begin
                                    pend_ok_next = 1'b1;
                                    pend_chr_next = cand_chr_reg;
                                end
                            end
                            else if (c != CH_STAR)
                            begin
                                pend_ok_next = 1'b1;
                                pend_chr_next = c;
                            end
                            if (field_reg < 3'd4)
                            begin
                                acc_next[field_reg[1:0]] = 32'd0;
                            end
                            phase_next = PH_END;
                        end
                    end
                    PH_FINT, PH_FFRAC:
                    begin
                        if (c_digit)
                        begin
                            if (phase_reg == PH_FINT)
                            begin
                                acc_next[field_reg[1:0]] = acc_dig;
                            end
                            else if (frac_reg < FD)
                            begin
                                acc_next[field_reg[1:0]] = acc_dig;
                                frac_next = frac_reg + 3'd1;
                            end
                        end
                        else if (c == CH_DOT && phase_reg == PH_FINT)
                        begin
                            phase_next = PH_FFRAC;
                        end
                        else
                        begin
                            // number done, move on and reparse this char
                            acc_next[field_reg[1:0]] = fin_val;
                            field_next = field_reg + 3'd1;
                            neg_next = 1'b0;
                            frac_next = 3'd0;
                            cand_ok_next = 1'b0;
                            cand_chr_next = 8'd0;
                            phase_next = (field_next >= 3'd4) ? PH_STAT : PH_FSTART;
                            again = (c != CH_COMMA);
                        end
                    end
                    PH_STAT:
                    begin
                        if (c != CH_SPACE)
                        begin
                            if (c != CH_STAR)
                            begin
                                pend_ok_next = 1'b1;
                                pend_chr_next = c;
                            end
                            phase_next = PH_END;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                // second pass: separator right after a number, fresh field
                if (again)
                begin
                    if (phase_next == PH_STAT)
                    begin
                        if (c != CH_SPACE)
                        begin
                            if (c != CH_STAR)
                            begin
                                pend_ok_next = 1'b1;
                                pend_chr_next = c;
                            end
                            phase_next = PH_END;
                        end
                    end
                    else if (c_ws)
                    begin
                        if (c != CH_SPACE)
                        begin
                            cand_ok_next = 1'b1;
                            cand_chr_next = c;
                        end
                        phase_next = PH_FWS;
                    end
                    else if (c_sign)
                    begin
                        cand_ok_next = 1'b1;
                        cand_chr_next = c;
                        neg_next = (c == CH_MINUS);
                        phase_next = PH_FSIGN;
                    end
                    else if (c == CH_DOT)
                    begin
                        cand_ok_next = 1'b1;
                        cand_chr_next = c;
                        phase_next = PH_FDOT;
                    end
                    else
                    begin
                        if (c != CH_STAR)
                        begin
                            pend_ok_next = 1'b1;
                            pend_chr_next = c;
                        end
                        acc_next[field_next[1:0]] = 32'd0;
                        phase_next = PH_END;
                    end
                end
            end
        end

        // end of text: close the open number or fail a half-started field
        if (do_te)
        begin
            if (phase_reg == PH_FWS || phase_reg == PH_FSIGN || phase_reg == PH_FDOT)
            begin
                if (cand_ok_reg && cand_chr_reg != CH_STAR)
                begin
                    pend_ok_next = 1'b1;
                    pend_chr_next = cand_chr_reg;
                end
                if (field_reg < 3'd4)
                begin
                    acc_next[field_reg[1:0]] = 32'd0;
                end
            end
            else if (phase_reg == PH_FINT || phase_reg == PH_FFRAC)
            begin
                acc_next[field_reg[1:0]] = fin_val;
            end
            phase_next = PH_END;
        end

        if (emit)
        begin
            if (pend_ok_next)
            begin
                status_next = pend_chr_next;
            end
            count_next = count_reg + 32'd1;
        end

        if (c == CH_LF)
        begin
            phase_next = PH_IDLE;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    // parser state, loads when the held item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            phase_reg <= PH_IDLE;
            field_reg <= 3'd0;
            for (int i = 0; i < 4; i++)
            begin
                acc_reg[i] <= 32'd0;
            end
            neg_reg <= 1'b0;
            frac_reg <= 3'd0;
            status_reg <= 8'd0;
            count_reg <= 32'd0;
            cand_ok_reg <= 1'b0;
            cand_chr_reg <= 8'd0;
            pend_ok_reg <= 1'b0;
            pend_chr_reg <= 8'd0;
        end
        else if (advance)
        begin
            len_reg <= len_next;
            phase_reg <= phase_next;
            field_reg <= field_next;
            for (int i = 0; i < 4; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
            neg_reg <= neg_next;
            frac_reg <= frac_next;
            status_reg <= status_next;
            count_reg <= count_next;
            cand_ok_reg <= cand_ok_next;
            cand_chr_reg <= cand_chr_next;
            pend_ok_reg <= pend_ok_next;
            pend_chr_reg <= pend_chr_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            vel_x_reg <= $signed(acc_next[0]);
            vel_y_reg <= $signed(acc_next[1]);
            vel_z_reg <= $signed(acc_next[2]);
            vel_err_reg <= $signed(acc_next[3]);
            status_out_reg <= status_next;
            total_out_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign vel_x       = vel_x_reg;
    assign vel_y       = vel_y_reg;
    assign vel_z       = vel_z_reg;
    assign vel_err     = vel_err_reg;
    assign status_char = status_out_reg;
    assign frame_total = total_out_reg;

endmodule

@@ design/vsp_scale.sv @@
// vsp_scale: turns a digit magnitude into a signed value in fixed-point units
// pads missing fraction digits by a power of ten, applies sign, saturates
// depends on vsp_pkg
`timescale 1ns / 1ps

module vsp_scale
    import vsp_pkg::*;
#(
    parameter int FRACTION_DIGITS = DEF_FRACTION_DIGITS
)
(
    input  logic [31:0]        mag,
    input  logic [2:0]         frac_seen,
    input  logic               neg,
    output logic signed [31:0] value
);

    localparam int SCALE_W = $clog2((10 ** FRACTION_DIGITS) + 1);
    localparam int PROD_W  = 32 + SCALE_W;
    localparam logic [2:0] FD = 3'(FRACTION_DIGITS);

    logic [2:0]        pad;
    logic [31:0]       scale_full;
    logic [SCALE_W-1:0] scale;
    logic [PROD_W-1:0] prod;
    logic [31:0]       clamped;

    always_comb
    begin
        pad = (FD > frac_seen) ? (FD - frac_seen) : 3'd0;
        scale_full = pow10(pad);
        scale = scale_full[SCALE_W-1:0];
        prod = {{SCALE_W{1'b0}}, mag} * {{32{1'b0}}, scale};
        if (prod > PROD_W'(MAG_LIMIT))
        begin
            clamped = MAG_LIMIT;
        end
        else
        begin
            clamped = prod[31:0];
        end
        if (neg)
        begin
            value = $signed(32'd0 - clamped);
        end
        else if (clamped > POS_MAX)
        begin
            value = $signed(POS_MAX);
        end
        else
        begin
            value = $signed(clamped);
        end
    end

endmodule
